[rtl/fat_table_engine_unit_macros.svh]
// ----------------------------------------------------------------------------
// fat table engine assertion macros
// concurrent assertion helpers clocked on clock, shared by the checker
// ----------------------------------------------------------------------------
`ifndef FAT_TABLE_ENGINE_UNIT_MACROS_SVH
`define FAT_TABLE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define FTE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fte assertion failed");

// next-cycle implication, off while reset is high
`define FTE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fte assertion failed");

// next-cycle implication that also holds across reset
`define FTE_ASSERT_ALWAYS_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("fte assertion failed");

`endif

[rtl/fte_pkg.sv]
// ----------------------------------------------------------------------------
// fte_pkg
// shared types and constants of the fat table engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fte_pkg;

   localparam int VALUE_W  = 28;
   localparam int INDEX_W  = 12;
   localparam int STATUS_W = 3;
   localparam int FUNC_W   = 2;
   localparam int COUNT_W  = 13;

   // entries at or above this mark end a chain
   localparam logic [VALUE_W-1:0] CHAIN_END = 28'hFFFFFF7;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NONE_FREE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_TRUNC     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BROKEN    = 3'd4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ      = 2'd0,
      FUNC_WRITE     = 2'd1,
      FUNC_FIND_FREE = 2'd2,
      FUNC_WALK      = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ONE,
      S_READ,
      S_SCAN,
      S_WALK
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]  index;
      logic [STATUS_W-1:0] status;
      logic                last;
   } result_type;

endpackage

[rtl/fte_ram.sv]
// ----------------------------------------------------------------------------
// fte_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fte_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fte_seq.sv]
// ----------------------------------------------------------------------------
// fte_seq
// request sequencer: clearing pass, entry access, free scan and chain walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fte_seq #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int MAX_CHAIN     = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fte_pkg::FUNC_W-1:0]       req_func,
   input  logic [fte_pkg::INDEX_W-1:0]      req_cluster,
   input  logic [fte_pkg::VALUE_W-1:0]      req_value_in,
   input  logic [fte_pkg::COUNT_W-1:0]      live_count,
   output logic                             wr_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   output logic [fte_pkg::VALUE_W-1:0]      wr_data,
   output logic                             rd_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   input  logic [fte_pkg::VALUE_W-1:0]      rd_data,
   output logic                             res_valid,
   output fte_pkg::result_type              res,
   input  logic                             res_free
);

   import fte_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int NW = $clog2(MAX_CHAIN + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
   localparam logic [NW-1:0] STEP_LAST = NW'(MAX_CHAIN - 1);

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [NW-1:0]    step_ff, step_in;
   result_type       one_ff, one_in;

   logic             accept;
   logic [VALUE_W-1:0] live_w;
   logic             in_range;
   logic             count_zero;
   logic             scan_hit, scan_done;
   logic             walk_free, walk_end, walk_broken, walk_trunc, walk_final;
   logic [STATUS_W-1:0] walk_status;
   result_type       range_res;

   assign accept     = req_valid && req_ready;
   assign live_w     = VALUE_W'(live_count);
   assign in_range   = VALUE_W'(req_cluster) < live_w;
   assign count_zero = (live_count == '0);
   assign range_res  = '{value: '0, index: req_cluster, status: STAT_RANGE, last: 1'b1};

   // scan decode on the entry that just came back
   assign scan_hit  = (rd_data == '0);
   assign scan_done = (VALUE_W'(cur_ff) + VALUE_W'(1)) >= live_w;

   // walk decode, order decides the status
   assign walk_free   = (rd_data == '0);
   assign walk_end    = (rd_data >= CHAIN_END);
   assign walk_broken = (rd_data >= live_w);
   assign walk_trunc  = (step_ff == STEP_LAST);
   assign walk_final  = walk_free || walk_end || walk_broken || walk_trunc;

   always_comb begin
      priority if (walk_free) begin
         walk_status = STAT_BROKEN;
      end else if (walk_end) begin
         walk_status = STAT_OK;
      end else if (walk_broken) begin
         walk_status = STAT_BROKEN;
      end else if (walk_trunc) begin
         walk_status = STAT_TRUNC;
      end else begin
         walk_status = STAT_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_func))
                  FUNC_READ:      state_in = in_range ? S_READ : S_ONE;
                  FUNC_WRITE:     state_in = S_ONE;
                  FUNC_FIND_FREE: state_in = count_zero ? S_ONE : S_SCAN;
                  FUNC_WALK:      state_in = in_range ? S_WALK : S_ONE;
               endcase
            end
         end
         S_ONE, S_READ: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (scan_hit || scan_done) begin
               state_in = S_ONE;
            end
         end
         S_WALK: begin
            if (res_free && walk_final) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs: handshake, memory port, result
   always_comb begin
      req_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = clr_ff;
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = AW'(req_cluster);
      res_valid = 1'b0;
      res       = one_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               unique case (func_type'(req_func))
                  FUNC_READ, FUNC_WALK: begin
                     rd_en = in_range;
                  end
                  FUNC_WRITE: begin
                     wr_en   = in_range;
                     wr_addr = AW'(req_cluster);
                     wr_data = req_value_in;
                  end
                  FUNC_FIND_FREE: begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                  end
               endcase
            end
         end
         S_ONE: begin
            res_valid = res_free;
         end
         S_READ: begin
            res_valid = res_free;
            res       = '{value: rd_data, index: INDEX_W'(cur_ff), status: STAT_OK,
                          last: 1'b1};
         end
         S_SCAN: begin
            if (!scan_hit && !scan_done) begin
               rd_en   = 1'b1;
               rd_addr = cur_ff + AW'(1);
            end
         end
         S_WALK: begin
            res = '{value: rd_data, index: INDEX_W'(cur_ff), status: walk_status,
                    last: walk_final};
            if (res_free) begin
               res_valid = 1'b1;
               if (!walk_final) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(rd_data);
               end
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      clr_in  = clr_ff;
      cur_in  = cur_ff;
      step_in = step_ff;
      one_in  = one_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         S_IDLE: begin
            if (accept) begin
               cur_in  = AW'(req_cluster);
               step_in = '0;
               unique case (func_type'(req_func))
                  FUNC_READ, FUNC_WALK: begin
                     one_in = range_res;
                  end
                  FUNC_WRITE: begin
                     one_in = in_range ? '{value: req_value_in, index: req_cluster,
                                           status: STAT_OK, last: 1'b1} : range_res;
                  end
                  FUNC_FIND_FREE: begin
                     cur_in = '0;
                     one_in = '{value: '0, index: '0, status: STAT_NONE_FREE, last: 1'b1};
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               one_in = '{value: '0, index: INDEX_W'(cur_ff), status: STAT_OK, last: 1'b1};
            end else if (scan_done) begin
               one_in = '{value: '0, index: '0, status: STAT_NONE_FREE, last: 1'b1};
            end else begin
               cur_in = cur_ff + AW'(1);
            end
         end
         S_WALK: begin
            if (res_free && !walk_final) begin
               cur_in  = AW'(rd_data);
               step_in = step_ff + NW'(1);
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      step_ff <= step_in;
      one_ff  <= one_in;
   end

endmodule

[rtl/fte_out.sv]
// ----------------------------------------------------------------------------
// fte_out
// result output register, frees the sequencer from the response side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fte_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         res_valid,
   input  fte_pkg::result_type          res,
   output logic                         res_free,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fte_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic [fte_pkg::INDEX_W-1:0]  rsp_index_out,
   output logic [fte_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_last
);

   import fte_pkg::*;

   logic       valid_ff;
   result_type res_ff;

   // slot is free when empty or being drained this cycle
   assign res_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_free) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_free && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_value_out = res_ff.value;
   assign rsp_index_out = res_ff.index;
   assign rsp_status    = res_ff.status;
   assign rsp_last      = res_ff.last;

endmodule

[rtl/fat_table_engine_unit.sv]
// ----------------------------------------------------------------------------
// fat_table_engine_unit
// read: the ram read register, then the output register; write: the result register, then the output register
// find free scans entries from index 0 upward; walk gives one result per cluster, up to MAX_CHAIN
// throughput: one request at a time; scans and
// walks hold off the next request until their last result is registered
// reset: table cleared by a sweep over all TABLE_ENTRIES entries, requests held off meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_table_engine_unit #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int MAX_CHAIN     = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [fte_pkg::FUNC_W-1:0]   req_func,
   input  logic [fte_pkg::INDEX_W-1:0]  req_cluster,
   input  logic [fte_pkg::VALUE_W-1:0]  req_value_in,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fte_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic [fte_pkg::INDEX_W-1:0]  rsp_index_out,
   output logic [fte_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_last,
   // cluster count register
   input  logic                         csr_we,
   input  logic [fte_pkg::COUNT_W-1:0]  csr_wdata
);

   import fte_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);

   // the count register saturates at the table size on write
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (TABLE_ENTRIES > 8191) ? {COUNT_W{1'b1}} : COUNT_W'(TABLE_ENTRIES);
   localparam logic [COUNT_W-1:0] COUNT_INIT =
      (COUNT_RESET > COUNT_CAP) ? COUNT_CAP : COUNT_RESET;

   logic [COUNT_W-1:0] live_count_ff, live_count_in;

   // table ram port
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   // sequencer to output register
   logic               res_valid;
   result_type         res;
   logic               res_free;

   // effective cluster count, stored already clipped to the table size
   assign live_count_in = (csr_wdata > COUNT_CAP) ? COUNT_CAP : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_count_ff <= COUNT_INIT;
      end else if (csr_we) begin
         live_count_ff <= live_count_in;
      end
   end

   // allocation table, one 28-bit entry per cluster
   fte_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // clearing pass, then one request at a time: access, scan or walk
   fte_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CHAIN     (MAX_CHAIN)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_cluster  (req_cluster),
      .req_value_in (req_value_in),
      .live_count   (live_count_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .res_valid    (res_valid),
      .res          (res),
      .res_free     (res_free)
   );

   // response register, a walk stalls here while the consumer holds off
   fte_out u_out (
      .clock         (clock),
      .reset         (reset),
      .res_valid     (res_valid),
      .res           (res),
      .res_free      (res_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_index_out (rsp_index_out),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

[rtl/fte_chk.sv]
// ----------------------------------------------------------------------------
// fte_chk
// port-level checker for the fat table engine, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fat_table_engine_unit_macros.svh"

module fte_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [fte_pkg::STATUS_W-1:0] rsp_status,
   input logic                         rsp_last
);

   import fte_pkg::*;

   // clearing pass holds off requests right after reset
   `FTE_ASSERT_ALWAYS_NXT(a_clear_after_reset, reset, !req_ready)

   // one request at a time
   `FTE_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

   // a stalled response stays
   `FTE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // only the final result of a walk carries a non-ok status
   `FTE_ASSERT_IMP(a_mid_chain_ok, rsp_valid && !rsp_last, rsp_status == STAT_OK)

   // status codes stay within the defined set
   `FTE_ASSERT_IMP(a_status_known, rsp_valid, rsp_status <= STAT_BROKEN)

endmodule

bind fat_table_engine_unit fte_chk u_fte_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);
